// ----- sv/priority_round_robin_task_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Shared property forms; clk_i and rst_ni must be in scope at the use site.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define PRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// prs_pkg
// Types, codes and defaults shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  typedef enum logic [3:0] {
    CMD_TICK    = 4'd0,
    CMD_CREATE  = 4'd1,
    CMD_REMOVE  = 4'd2,
    CMD_START   = 4'd3,
    CMD_STOP    = 4'd4,
    CMD_SETPRIO = 4'd5,
    CMD_YIELD   = 4'd6,
    CMD_DELAY   = 4'd7,
    CMD_GETPRIO = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_WAITING = 3'd3,
    ST_STOPPED = 3'd4,
    ST_TERM    = 3'd5
  } slot_st_e;

  typedef enum logic [1:0] {
    RS_DONE    = 2'd0,
    RS_NOFREE  = 2'd1,
    RS_IGNORED = 2'd2
  } res_st_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  slot;
    logic [7:0]  priority_req;
    logic [31:0] delay_us;
    logic [31:0] now;
  } cmd_word_t;

  typedef struct packed {
    res_st_e     status;
    logic [2:0]  result_slot;
    logic [2:0]  current_slot;
    logic        is_idle;
    logic        any_pending;
    logic [7:0]  slot_priority;
  } res_word_t;

  typedef struct packed {
    slot_st_e    st;
    logic [7:0]  prio;
    logic [31:0] wake;
  } slot_ent_t;

  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
    slot_st_e    st;
    logic [7:0]  prio;
    logic [7:0]  best_prio;
    logic        found;
  } eval_req_t;

  typedef struct packed {
    logic        take;
    logic        woke;
    logic [31:0] sum;
  } eval_rsp_t;

endpackage

// ----- sv/prs_slot_mem.sv -----
// ----------------------------------------------------------------------------
// prs_slot_mem
// Slot table: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
module prs_slot_mem #(
  parameter int unsigned SLOTS = prs_pkg::SLOTS_DEF,
  localparam int unsigned SW   = $clog2(SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [SW-1:0]       waddr_i,
  input  prs_pkg::slot_ent_t  wdata_i,
  input  logic [SW-1:0]       raddr_i,
  output prs_pkg::slot_ent_t  rdata_o,
  output logic [SLOTS-1:0]    live_o
);
  import prs_pkg::*;

  slot_ent_t        mem_q [SLOTS];
  slot_ent_t        rd_q;
  logic [SLOTS-1:0] vld_q;
  logic [SLOTS-1:0] live_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      live_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i]  <= 1'b1;
        live_q[waddr_i] <= !(wdata_i.st == ST_UNUSED || wdata_i.st == ST_TERM);
      end
    end
  end

  // entries never written read as the reset value
  assign rdata_o = rvld_q ? rd_q : '0;
  assign live_o  = live_q;

endmodule

// ----- sv/prs_eval.sv -----
// ----------------------------------------------------------------------------
// prs_eval
// Shared unit: one 32-bit adder plus the eligibility and priority compare.
// ----------------------------------------------------------------------------
module prs_eval (
  input  prs_pkg::eval_req_t req_i,
  output prs_pkg::eval_rsp_t rsp_o
);
  import prs_pkg::*;

  logic [31:0] b_op;
  logic [31:0] sum;
  logic        woke;
  logic        elig;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign sum  = req_i.a + b_op + {31'd0, req_i.sub};

  // wrap-safe: wake time passed when now - wake is below 2^31
  assign woke = (req_i.st == ST_WAITING) && !sum[31];
  assign elig = (req_i.st == ST_READY) || (req_i.st == ST_RUNNING) || woke;

  assign rsp_o.sum  = sum;
  assign rsp_o.woke = woke;
  assign rsp_o.take = elig && (!req_i.found || (req_i.prio < req_i.best_prio));

endmodule

// ----- sv/priority_round_robin_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top
// Sequence: decode, then a read and a modify step for the slot commands, a search for
//   a free slot for create, a schedule pass where the command needs one, then the result word;
//   the single slot table read port, one slot per cycle, sets the scan length.
// Throughput: one word at a time, busy until done_o; the receiver cannot stall.
// Reset: asynchronous, all slots unused, idle, rotation pointer at slot 0.
// ----------------------------------------------------------------------------
`include "priority_round_robin_task_scheduler_top_defines.svh"

module priority_round_robin_task_scheduler_top #(
  parameter int unsigned SLOTS = prs_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  prs_pkg::cmd_word_t cmd_i,
  output logic               done_o,
  output prs_pkg::res_word_t res_o
);
  import prs_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CMD_RD, S_CMD_MOD, S_CREATE, S_SCAN, S_PICK,
    S_DEM_RD, S_DEM_MOD, S_PRO_RD, S_PRO_MOD, S_DONE
  } state_e;

  state_e      state_q, state_d;
  cmd_word_t   cmd_q, cmd_d;
  logic [SW-1:0] addr_q, addr_d, prev_q, prev_d, best_q, best_d;
  logic [SW-1:0] run_q, run_d, rot_q, rot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        ev_q, ev_d, found_q, found_d, idle_q, idle_d, done_q, done_d;
  logic [7:0]  bprio_q, bprio_d, sprio_q, sprio_d;
  res_st_e     rstat_q, rstat_d;
  logic [2:0]  rslot_q, rslot_d;
  res_word_t   res_q, res_d;

  logic             we;
  logic [SW-1:0]    waddr;
  slot_ent_t        wdata;
  slot_ent_t        ent;
  logic [SLOTS-1:0] live;
  eval_req_t        ereq;
  eval_rsp_t        ersp;

  logic [SW-1:0] slot_idx;
  logic          slot_ok;
  logic          on_run;
  logic          go_scan;

  function automatic logic [SW-1:0] inc_idx(input logic [SW-1:0] v);
    return (v == LAST) ? '0 : v + 1'b1;
  endfunction

  prs_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (ent),
    .live_o  (live)
  );

  prs_eval u_eval (
    .req_i (ereq),
    .rsp_o (ersp)
  );

  assign slot_idx = SW'(cmd_q.slot);
  assign slot_ok  = 6'(cmd_q.slot) < 6'(SLOTS);
  assign on_run   = !idle_q && (slot_idx == run_q);
  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign res_o    = res_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    prev_d  = prev_q;
    best_d  = best_q;
    run_d   = run_q;
    rot_d   = rot_q;
    cnt_d   = cnt_q;
    ev_d    = ev_q;
    found_d = found_q;
    idle_d  = idle_q;
    bprio_d = bprio_q;
    sprio_d = sprio_q;
    rstat_d = rstat_q;
    rslot_d = rslot_q;
    res_d   = res_q;
    done_d  = 1'b0;
    go_scan = 1'b0;

    we    = 1'b0;
    waddr = addr_q;
    wdata = ent;

    ereq.sub       = 1'b1;
    ereq.a         = cmd_q.now;
    ereq.b         = ent.wake;
    ereq.st        = ent.st;
    ereq.prio      = ent.prio;
    ereq.best_prio = bprio_q;
    ereq.found     = found_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          rstat_d = RS_DONE;
          rslot_d = cmd_i.slot;
          sprio_d = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd_q.command)
          CMD_TICK: go_scan = 1'b1;
          CMD_CREATE: begin
            addr_d  = '0;
            rslot_d = '0;
            state_d = S_CREATE;
          end
          CMD_REMOVE, CMD_START, CMD_STOP, CMD_SETPRIO, CMD_GETPRIO: begin
            if (!slot_ok) begin
              rstat_d = RS_IGNORED;
              state_d = S_DONE;
            end else begin
              addr_d  = slot_idx;
              state_d = S_CMD_RD;
            end
          end
          CMD_YIELD, CMD_DELAY: begin
            if (idle_q) begin
              rstat_d = RS_IGNORED;
              state_d = S_DONE;
            end else begin
              addr_d  = run_q;
              state_d = S_CMD_RD;
            end
          end
          default: begin
            rstat_d = RS_IGNORED;
            state_d = S_DONE;
          end
        endcase
      end
      S_CMD_RD: state_d = S_CMD_MOD;
      S_CMD_MOD: begin
        state_d = S_DONE;
        case (cmd_q.command)
          CMD_REMOVE: begin
            we       = 1'b1;
            wdata.st = on_run ? ST_TERM : ST_UNUSED;
            go_scan  = on_run;
          end
          CMD_START: begin
            if (ent.st == ST_STOPPED) begin
              we       = 1'b1;
              wdata.st = ST_READY;
            end else begin
              rstat_d = RS_IGNORED;
            end
          end
          CMD_STOP: begin
            if (ent.st == ST_READY || ent.st == ST_RUNNING || ent.st == ST_WAITING) begin
              we       = 1'b1;
              wdata.st = ST_STOPPED;
              go_scan  = on_run;
            end else begin
              rstat_d = RS_IGNORED;
            end
          end
          CMD_SETPRIO: begin
            we         = 1'b1;
            wdata.prio = cmd_q.priority_req;
          end
          CMD_GETPRIO: sprio_d = ent.prio;
          CMD_YIELD: begin
            if (ent.st == ST_RUNNING) begin
              we       = 1'b1;
              wdata.st = ST_READY;
            end
            go_scan = 1'b1;
          end
          CMD_DELAY: begin
            if (cmd_q.delay_us == '0) begin
              if (ent.st == ST_RUNNING) begin
                we       = 1'b1;
                wdata.st = ST_READY;
              end
            end else begin
              ereq.sub   = 1'b0;
              ereq.b     = cmd_q.delay_us;
              we         = 1'b1;
              wdata.wake = ersp.sum;
              wdata.st   = ST_WAITING;
            end
            go_scan = 1'b1;
          end
          default: rstat_d = RS_IGNORED;
        endcase
      end
      S_CREATE: begin
        if (!live[addr_q]) begin
          we         = 1'b1;
          wdata.st   = ST_READY;
          wdata.prio = cmd_q.priority_req;
          wdata.wake = '0;
          rslot_d    = 3'(addr_q);
          state_d    = S_DONE;
        end else if (addr_q == LAST) begin
          rstat_d = RS_NOFREE;
          rslot_d = '0;
          state_d = S_DONE;
        end else begin
          addr_d = inc_idx(addr_q);
        end
      end
      S_SCAN: begin
        if (cnt_q != CW'(SLOTS)) begin
          addr_d = inc_idx(addr_q);
          prev_d = addr_q;
          ev_d   = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          ev_d = 1'b0;
        end
        if (ev_q) begin
          waddr = prev_q;
          if (ersp.woke) begin
            we       = 1'b1;
            wdata.st = ST_READY;
          end
          if (ersp.take) begin
            found_d = 1'b1;
            best_d  = prev_q;
            bprio_d = ent.prio;
          end
          if (cnt_q == CW'(SLOTS)) begin
            state_d = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (!found_q) begin
          idle_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          rot_d = best_q;
          if (!idle_q && best_q != run_q) begin
            addr_d  = run_q;
            state_d = S_DEM_RD;
          end else begin
            addr_d  = best_q;
            state_d = S_PRO_RD;
          end
        end
      end
      S_DEM_RD: state_d = S_DEM_MOD;
      S_DEM_MOD: begin
        if (ent.st == ST_RUNNING) begin
          we       = 1'b1;
          wdata.st = ST_READY;
        end
        addr_d  = best_q;
        state_d = S_PRO_RD;
      end
      S_PRO_RD: state_d = S_PRO_MOD;
      S_PRO_MOD: begin
        we       = 1'b1;
        wdata.st = ST_RUNNING;
        run_d    = best_q;
        idle_d   = 1'b0;
        state_d  = S_DONE;
      end
      S_DONE: begin
        done_d              = 1'b1;
        res_d.status        = rstat_q;
        res_d.result_slot   = rslot_q;
        res_d.current_slot  = idle_q ? 3'd0 : 3'(run_q);
        res_d.is_idle       = idle_q;
        res_d.any_pending   = |live;
        res_d.slot_priority = sprio_q;
        state_d             = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (go_scan) begin
      addr_d  = inc_idx(rot_q);
      cnt_d   = '0;
      ev_d    = 1'b0;
      found_d = 1'b0;
      state_d = S_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      addr_q  <= '0;
      prev_q  <= '0;
      best_q  <= '0;
      run_q   <= '0;
      rot_q   <= '0;
      cnt_q   <= '0;
      ev_q    <= 1'b0;
      found_q <= 1'b0;
      idle_q  <= 1'b1;
      bprio_q <= '0;
      sprio_q <= '0;
      rstat_q <= RS_DONE;
      rslot_q <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      prev_q  <= prev_d;
      best_q  <= best_d;
      run_q   <= run_d;
      rot_q   <= rot_d;
      cnt_q   <= cnt_d;
      ev_q    <= ev_d;
      found_q <= found_d;
      idle_q  <= idle_d;
      bprio_q <= bprio_d;
      sprio_q <= sprio_d;
      rstat_q <= rstat_d;
      rslot_q <= rslot_d;
      res_q   <= res_d;
      done_q  <= done_d;
    end
  end

  `PRS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `PRS_ASSERT_IMP(a_done_end, done_o, $past(busy) && !busy, "done strobe outside command end")
  `PRS_ASSERT_IMP(a_nofree_full, done_o && res_o.status == RS_NOFREE, (&live) && res_o.any_pending, "create failed with a free slot")
  `PRS_ASSERT_IMP(a_promote_found, state_q == S_PRO_MOD, found_q && !idle_d, "promotion without a winner")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the priority round-robin task scheduler
// Drives command words through the start/busy handshake. It walks a short
// table of directed commands first, then 1600 random commands, with random
// sender gaps. A scheduler model in the bench predicts each result word not
// given by a directed row, and each done_o strobe is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import prs_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int N_SLOTS      = SLOTS_DEF;
  localparam int N_ITEMS      = 1600;
  localparam int CALM_TAIL    = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT    = 400000;

  localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
  localparam logic [3:0] CMD_UNDEF_HI = 4'd15;

  typedef struct {
    cmd_word_t w;
    logic      chk;
    res_word_t r;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  cmd_word_t cmd_i;
  logic      done_o;
  res_word_t res_o;

  logic      use_typed;
  res_word_t typed_res;

  // scheduler model state
  slot_st_e    mdl_st   [N_SLOTS];
  logic [7:0]  mdl_prio [N_SLOTS];
  logic [31:0] mdl_wake [N_SLOTS];
  logic [2:0]  mdl_run;
  logic        mdl_idle;
  logic [2:0]  mdl_rot;

  res_word_t   sched_results_q[$];
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned mismatch_cnt;
  int unsigned nofree_cnt;
  int unsigned wake_cnt;

  priority_round_robin_task_scheduler_top #(
    .SLOTS(N_SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic bit pick_next(input logic [31:0] now, output logic [2:0] pick);
    bit          found;
    logic [2:0]  best;
    int          idx;
    logic [31:0] age;
    found = 1'b0;
    best  = '0;
    for (int k = 1; k <= N_SLOTS; k++) begin
      idx = (int'(mdl_rot) + k) % N_SLOTS;
      if (mdl_st[idx] == ST_WAITING) begin
        age = now - mdl_wake[idx];
        if (age[31]) continue;
        mdl_st[idx] = ST_READY;
        wake_cnt++;
      end else if (mdl_st[idx] != ST_READY && mdl_st[idx] != ST_RUNNING) begin
        continue;
      end
      if (!found || mdl_prio[idx] < mdl_prio[best]) begin
        best  = 3'(idx);
        found = 1'b1;
      end
    end
    if (found) mdl_rot = best;
    pick = best;
    return found;
  endfunction

  function automatic void run_pass(input logic [31:0] now);
    logic [2:0] nxt;
    if (!pick_next(now, nxt)) begin
      mdl_idle = 1'b1;
      return;
    end
    if (!mdl_idle && nxt == mdl_run) begin
      mdl_st[nxt] = ST_RUNNING;
      return;
    end
    if (!mdl_idle && mdl_st[mdl_run] == ST_RUNNING) mdl_st[mdl_run] = ST_READY;
    mdl_st[nxt] = ST_RUNNING;
    mdl_run     = nxt;
    mdl_idle    = 1'b0;
  endfunction

  function automatic res_st_e yield_running(input logic [31:0] now);
    if (mdl_idle) return RS_IGNORED;
    if (mdl_st[mdl_run] == ST_RUNNING) mdl_st[mdl_run] = ST_READY;
    run_pass(now);
    return RS_DONE;
  endfunction

  function automatic res_word_t next_sched_result(input cmd_word_t w);
    res_word_t  r;
    res_st_e    st;
    logic [2:0] rs;
    logic [7:0] sp;
    logic       pend;
    st   = RS_DONE;
    rs   = w.slot;
    sp   = '0;
    pend = 1'b0;
    case (w.command)
      CMD_TICK: run_pass(w.now);
      CMD_CREATE: begin
        st = RS_NOFREE;
        rs = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (mdl_st[i] == ST_UNUSED || mdl_st[i] == ST_TERM) begin
            mdl_wake[i] = '0;
            mdl_prio[i] = w.priority_req;
            mdl_st[i]   = ST_READY;
            st          = RS_DONE;
            rs          = 3'(i);
            break;
          end
        end
        if (st == RS_NOFREE) nofree_cnt++;
      end
      CMD_REMOVE: begin
        if (!mdl_idle && w.slot == mdl_run) begin
          mdl_st[w.slot] = ST_TERM;
          run_pass(w.now);
        end else begin
          mdl_st[w.slot] = ST_UNUSED;
        end
      end
      CMD_START: begin
        if (mdl_st[w.slot] != ST_STOPPED) st = RS_IGNORED;
        else mdl_st[w.slot] = ST_READY;
      end
      CMD_STOP: begin
        if (mdl_st[w.slot] == ST_READY || mdl_st[w.slot] == ST_RUNNING ||
            mdl_st[w.slot] == ST_WAITING) begin
          mdl_st[w.slot] = ST_STOPPED;
          if (!mdl_idle && w.slot == mdl_run) run_pass(w.now);
        end else begin
          st = RS_IGNORED;
        end
      end
      CMD_SETPRIO: mdl_prio[w.slot] = w.priority_req;
      CMD_YIELD: st = yield_running(w.now);
      CMD_DELAY: begin
        if (w.delay_us == '0) begin
          st = yield_running(w.now);
        end else if (mdl_idle) begin
          st = RS_IGNORED;
        end else begin
          mdl_wake[mdl_run] = w.now + w.delay_us;
          mdl_st[mdl_run]   = ST_WAITING;
          run_pass(w.now);
        end
      end
      CMD_GETPRIO: sp = mdl_prio[w.slot];
      default: st = RS_IGNORED;
    endcase
    for (int i = 0; i < N_SLOTS; i++)
      if (mdl_st[i] != ST_UNUSED && mdl_st[i] != ST_TERM) pend = 1'b1;
    r.status        = st;
    r.result_slot   = rs;
    r.current_slot  = mdl_idle ? '0 : mdl_run;
    r.is_idle       = mdl_idle;
    r.any_pending   = pend;
    r.slot_priority = sp;
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  function automatic cmd_word_t mk_cmd(input logic [3:0] c, input logic [2:0] s,
                                       input logic [7:0] p, input logic [31:0] d,
                                       input logic [31:0] t);
    cmd_word_t w;
    w.command      = c;
    w.slot         = s;
    w.priority_req = p;
    w.delay_us     = d;
    w.now          = t;
    return w;
  endfunction

  function automatic res_word_t mk_res(input res_st_e s, input logic [2:0] rs,
                                       input logic [2:0] cur, input logic idl,
                                       input logic pend, input logic [7:0] sp);
    res_word_t r;
    r.status        = s;
    r.result_slot   = rs;
    r.current_slot  = cur;
    r.is_idle       = idl;
    r.any_pending   = pend;
    r.slot_priority = sp;
    return r;
  endfunction

  // results first, then the accept: both are sampled before this edge updates
  always @(posedge clk_i) begin
    res_word_t want;
    res_word_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (sched_results_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_cnt++;
        end else begin
          want = sched_results_q.pop_front();
          checked_cnt++;
          cmp_field("status",        32'(want.status),        32'(res_o.status));
          cmp_field("result_slot",   32'(want.result_slot),   32'(res_o.result_slot));
          cmp_field("current_slot",  32'(want.current_slot),  32'(res_o.current_slot));
          cmp_field("is_idle",       32'(want.is_idle),       32'(res_o.is_idle));
          cmp_field("any_pending",   32'(want.any_pending),   32'(res_o.any_pending));
          cmp_field("slot_priority", 32'(want.slot_priority), 32'(res_o.slot_priority));
        end
      end
      if (start && !busy) begin
        accepted_cnt++;
        pred = next_sched_result(cmd_i);
        sched_results_q.push_back(use_typed ? typed_res : pred);
      end
    end
  end

  task automatic issue(input cmd_word_t w, input logic typed, input res_word_t er);
    while (busy !== 1'b0) @(negedge clk_i);
    start     <= 1'b1;
    cmd_i     <= w;
    use_typed <= typed;
    typed_res <= er;
    @(negedge clk_i);
  endtask

  initial begin
    dir_row_t    plan[$];
    cmd_word_t   w;
    logic [31:0] now_us;
    int          sel;
    start        = 1'b0;
    cmd_i        = '0;
    use_typed    = 1'b0;
    typed_res    = '0;
    rst_ni       = 1'b0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    mismatch_cnt = 0;
    nofree_cnt   = 0;
    wake_cnt     = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      mdl_st[i]   = ST_UNUSED;
      mdl_prio[i] = '0;
      mdl_wake[i] = '0;
    end
    mdl_run  = '0;
    mdl_idle = 1'b1;
    mdl_rot  = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle block: nothing to run, yield/delay refused, empty table
    plan.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0), 1'b1,
                     mk_res(RS_DONE, 0, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_YIELD, 0, 0, 0, 0), 1'b1,
                     mk_res(RS_IGNORED, 0, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_DELAY, 0, 0, 5, 0), 1'b1,
                     mk_res(RS_IGNORED, 0, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_GETPRIO, 7, 0, 0, 0), 1'b1,
                     mk_res(RS_DONE, 7, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_START, 3, 0, 0, 0), 1'b1,
                     mk_res(RS_IGNORED, 3, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_STOP, 3, 0, 0, 0), 1'b1,
                     mk_res(RS_IGNORED, 3, 0, 1'b1, 1'b0, 0)});
    plan.push_back('{mk_cmd(CMD_UNDEF_HI, 5, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                     mk_res(RS_IGNORED, 5, 0, 1'b1, 1'b0, 0)});
    // fill every slot, then one create too many
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd255, 0, 0), 1'b1,
                     mk_res(RS_DONE, 0, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd0, 0, 0), 1'b1,
                     mk_res(RS_DONE, 1, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd7, 0, 0), 1'b1,
                     mk_res(RS_DONE, 2, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd7, 0, 0), 1'b1,
                     mk_res(RS_DONE, 3, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd128, 0, 0), 1'b1,
                     mk_res(RS_DONE, 4, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd1, 0, 0), 1'b1,
                     mk_res(RS_DONE, 5, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd1, 0, 0), 1'b1,
                     mk_res(RS_DONE, 6, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd200, 0, 0), 1'b1,
                     mk_res(RS_DONE, 7, 0, 1'b1, 1'b1, 0)});
    plan.push_back('{mk_cmd(CMD_CREATE, 7, 8'd3, 0, 0), 1'b1,
                     mk_res(RS_NOFREE, 0, 0, 1'b1, 1'b1, 0)});
    // scheduling: ties, very long delay, zero delay, wake across the wrap
    plan.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 100), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_SETPRIO, 0, 8'd0, 0, 110), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_GETPRIO, 0, 0, 0, 120), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_DELAY, 0, 0, 32'hFFFF_FFFF, 200), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_DELAY, 0, 0, 0, 210), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_DELAY, 0, 0, 1000, 32'hFFFF_FF00), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 32'h0000_0400), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_STOP, 1, 0, 0, 32'h0000_0410), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_START, 1, 0, 0, 32'h0000_0420), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_REMOVE, 2, 0, 0, 32'h0000_0430), 1'b0, '0});

    foreach (plan[i]) issue(plan[i].w, plan[i].chk, plan[i].r);

    // hold off until every result word is back
    start <= 1'b0;
    do @(negedge clk_i); while (sched_results_q.size() != 0);

    now_us = $urandom();
    for (int n = 0; n < N_ITEMS; n++) begin
      if (n < N_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      sel = $urandom_range(0, 99);
      if (sel < 22)      w.command = CMD_TICK;
      else if (sel < 36) w.command = CMD_CREATE;
      else if (sel < 44) w.command = CMD_REMOVE;
      else if (sel < 52) w.command = CMD_START;
      else if (sel < 62) w.command = CMD_STOP;
      else if (sel < 68) w.command = CMD_SETPRIO;
      else if (sel < 76) w.command = CMD_YIELD;
      else if (sel < 90) w.command = CMD_DELAY;
      else if (sel < 96) w.command = CMD_GETPRIO;
      else               w.command = 4'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      w.slot = 3'($urandom_range(0, N_SLOTS - 1));
      if ((w.command == CMD_REMOVE || w.command == CMD_STOP) && $urandom_range(0, 1))
        w.slot = mdl_run;
      w.priority_req = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 10)      w.delay_us = '0;
      else if (sel < 75) w.delay_us = 32'($urandom_range(1, 60));
      else if (sel < 85) w.delay_us = $urandom() | 32'h8000_0000;
      else               w.delay_us = $urandom();
      if ($urandom_range(0, 49) == 0) now_us = $urandom();
      else now_us = now_us + 32'($urandom_range(0, 24));
      w.now = now_us;
      issue(w, 1'b0, '0);
    end

    start <= 1'b0;
    do @(negedge clk_i); while (sched_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d result words.", accepted_cnt, checked_cnt);
    $display("%0d creates found the table full, %0d waiting slots woke up.",
             nofree_cnt, wake_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- priority_round_robin_task_scheduler_top.f -----
+incdir+sv
sv/prs_pkg.sv
sv/prs_slot_mem.sv
sv/prs_eval.sv
sv/priority_round_robin_task_scheduler_top.sv
tb/sv/tb_top.sv
